>>> rtl/pmr_pkg.sv
// Shared types, constants and the per-axis cursor move function for the
// PS/2 mouse receiver. No dependencies.
`default_nettype none

package pmr_pkg;

  // Field widths fixed by the item formats.
  localparam int POS_BITS   = 10;
  localparam int BYTE_BITS  = 8;
  localparam int IDX_BITS   = 3;
  localparam int DATA_BITS  = 10;
  localparam int EDGE_BITS  = 4;

  // Frame layout: start, eight data bits, parity, stop.
  localparam logic [EDGE_BITS-1:0] FIRST_DATA_EDGE = 4'd2;
  localparam logic [EDGE_BITS-1:0] LAST_DATA_EDGE  = 4'd9;
  localparam logic [EDGE_BITS-1:0] FRAME_EDGES     = 4'd11;

  // Packet byte 0 bit positions.
  localparam int LEFT_BIT   = 0;
  localparam int RIGHT_BIT  = 1;
  localparam int X_SIGN_BIT = 4;
  localparam int Y_SIGN_BIT = 5;

  // Bias of the nine-bit two's complement move.
  localparam logic [8:0] MOVE_BIAS = 9'd256;

  // Register reset values.
  localparam logic [POS_BITS-1:0] X_MAX_RST  = 10'd479;
  localparam logic [POS_BITS-1:0] Y_MAX_RST  = 10'd271;
  localparam logic [POS_BITS-1:0] X_HOME_RST = 10'd240;
  localparam logic [POS_BITS-1:0] Y_HOME_RST = 10'd136;

  // Default depth of the command queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Configuration register indexes.
  typedef enum logic [IDX_BITS-1:0] {
    REG_CAPTURE = 3'd0,
    REG_X_MAX   = 3'd1,
    REG_Y_MAX   = 3'd2,
    REG_X_HOME  = 3'd3,
    REG_Y_HOME  = 3'd4
  } cfg_reg_t;

  // Input request kinds.
  typedef enum logic {
    REQ_EDGE = 1'b0,
    REQ_HOME = 1'b1
  } req_kind_t;

  // Commands passed from the frame front end to the cursor back end.
  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_HOME = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic req_type;
    logic data_level;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] rx_byte;
    logic                 packet_done;
    logic                 left_button;
    logic                 right_button;
    logic [POS_BITS-1:0]  cursor_x;
    logic [POS_BITS-1:0]  cursor_y;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [BYTE_BITS-1:0] rx_byte;
  } cmd_t;

  typedef struct packed {
    logic                capture_enable;
    logic [POS_BITS-1:0] x_max;
    logic [POS_BITS-1:0] y_max;
    logic [POS_BITS-1:0] x_home;
    logic [POS_BITS-1:0] y_home;
  } cfg_t;

  // Move one axis by a packet delta. A negative move only applies if the
  // position stays at or above zero; a positive one only if it stays at or
  // below the limit.
  function automatic logic [POS_BITS-1:0] move_axis(
    input logic [POS_BITS-1:0]  pos,
    input logic                 negative,
    input logic [BYTE_BITS-1:0] delta,
    input logic [POS_BITS-1:0]  lim
  );
    logic [8:0]          mag;
    logic [POS_BITS:0]   sum;
    logic [POS_BITS-1:0] res;
    mag = MOVE_BIAS - {1'b0, delta};
    sum = {1'b0, pos} + {{(POS_BITS + 1 - BYTE_BITS){1'b0}}, delta};
    res = pos;
    if (negative) begin
      if ({1'b0, pos} >= {{(POS_BITS - 8){1'b0}}, mag}) begin
        res = pos - {{(POS_BITS - 9){1'b0}}, mag};
      end
    end else begin
      if (sum <= {1'b0, lim}) begin
        res = sum[POS_BITS-1:0];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/pmr_front.sv
// Frame front end: counts the items of each PS/2 frame, shifts in data bits and turns
// completed bytes and home requests into queue commands. Uses pmr_pkg.
`default_nettype none

module pmr_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire pmr_pkg::in_item_t in_item,
  input  wire logic             q_full,
  output logic                  q_push,
  output pmr_pkg::cmd_t         q_cmd
);
  import pmr_pkg::*;

  logic [EDGE_BITS-1:0] edge_count;
  logic [EDGE_BITS-1:0] edge_count_next;
  logic [BYTE_BITS-1:0] shift_byte;
  logic [BYTE_BITS-1:0] shift_byte_next;
  logic [EDGE_BITS-1:0] edge_inc;
  logic                 frame_end;
  logic                 needs_push;
  logic                 take;

  // An item needs queue space only if it completes a byte or is a home.
  always_comb begin
    edge_inc   = edge_count + 4'd1;
    frame_end  = (edge_inc >= FRAME_EDGES);
    needs_push = (in_item.req_type == REQ_HOME) || frame_end;
    in_stall   = q_full && needs_push;
    take       = in_valid && !in_stall;
    q_push     = take && needs_push;
    q_cmd.kind    = (in_item.req_type == REQ_HOME) ? CMD_HOME : CMD_BYTE;
    q_cmd.rx_byte = shift_byte;
  end

  // Edge counter and shift register update.
  always_comb begin
    edge_count_next = edge_count;
    shift_byte_next = shift_byte;
    if (take) begin
      if (in_item.req_type == REQ_HOME || frame_end) begin
        edge_count_next = '0;
        shift_byte_next = '0;
      end else begin
        edge_count_next = edge_inc;
        if (edge_inc >= FIRST_DATA_EDGE && edge_inc <= LAST_DATA_EDGE) begin
          shift_byte_next = {in_item.data_level, shift_byte[BYTE_BITS-1:1]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
      shift_byte <= '0;
    end else begin
      edge_count <= edge_count_next;
      shift_byte <= shift_byte_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pmr_queue.sv
// Short command queue that decouples the frame front end from the cursor
// back end. Uses pmr_pkg for the command type.
`default_nettype none

module pmr_queue #(
  parameter int DEPTH = pmr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire pmr_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output pmr_pkg::cmd_t      head_cmd
);
  import pmr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  cmd_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage is written at the tail; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/pmr_back.sv
// Cursor back end: gathers bytes into three-byte packets, applies button
// and cursor updates and holds the result register. Uses pmr_pkg.
`default_nettype none

module pmr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pmr_pkg::cfg_t  cfg,
  input  wire logic           head_valid,
  input  wire pmr_pkg::cmd_t  head_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output pmr_pkg::out_item_t  out_item
);
  import pmr_pkg::*;

  logic [1:0]           packet_index;
  logic [1:0]           packet_index_next;
  logic [BYTE_BITS-1:0] store0;
  logic [BYTE_BITS-1:0] store1;
  logic [1:0]           buttons;
  logic [1:0]           buttons_next;
  logic [POS_BITS-1:0]  pos_x;
  logic [POS_BITS-1:0]  pos_x_next;
  logic [POS_BITS-1:0]  pos_y;
  logic [POS_BITS-1:0]  pos_y_next;
  logic                 done;
  logic                 is_home;
  logic                 load_out;
  logic                 wr_store0;
  logic                 wr_store1;

  // A home command never produces a result, so it drains even while the
  // result register is blocked.
  always_comb begin
    is_home  = (head_cmd.kind == CMD_HOME);
    q_pop    = head_valid && (is_home || !out_valid || !out_stall);
    load_out = q_pop && !is_home;
  end

  // Packet assembly and cursor update.
  always_comb begin
    packet_index_next = packet_index;
    buttons_next      = buttons;
    pos_x_next        = pos_x;
    pos_y_next        = pos_y;
    done              = 1'b0;
    wr_store0         = 1'b0;
    wr_store1         = 1'b0;
    if (q_pop) begin
      if (is_home) begin
        pos_x_next        = cfg.x_home;
        pos_y_next        = cfg.y_home;
        packet_index_next = '0;
      end else if (cfg.capture_enable) begin
        if (packet_index == 2'd0) begin
          wr_store0         = 1'b1;
          packet_index_next = 2'd1;
        end else if (packet_index == 2'd1) begin
          wr_store1         = 1'b1;
          packet_index_next = 2'd2;
        end else begin
          buttons_next      = {store0[RIGHT_BIT], store0[LEFT_BIT]};
          pos_x_next        = move_axis(pos_x, store0[X_SIGN_BIT], store1, cfg.x_max);
          pos_y_next        = move_axis(pos_y, store0[Y_SIGN_BIT], head_cmd.rx_byte,
                                        cfg.y_max);
          packet_index_next = '0;
          done              = 1'b1;
        end
      end
    end
  end

  // Packet bytes are always written before they are read.
  always_ff @(posedge clk) begin
    if (wr_store0) begin
      store0 <= head_cmd.rx_byte;
    end
    if (wr_store1) begin
      store1 <= head_cmd.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_index <= '0;
      buttons      <= '0;
      pos_x        <= X_HOME_RST;
      pos_y        <= Y_HOME_RST;
    end else begin
      packet_index <= packet_index_next;
      buttons      <= buttons_next;
      pos_x        <= pos_x_next;
      pos_y        <= pos_y_next;
    end
  end

  // Result register: filled on a byte command, emptied by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.rx_byte      <= head_cmd.rx_byte;
      out_item.packet_done  <= done;
      out_item.left_button  <= buttons_next[0];
      out_item.right_button <= buttons_next[1];
      out_item.cursor_x     <= pos_x_next;
      out_item.cursor_y     <= pos_y_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ps2_mouse_receiver_cursor.sv
// Top level of the PS/2 mouse receiver with cursor tracking: holds the
// configuration registers and connects pmr_front, pmr_queue and pmr_back.
//
// Usage:
//   in channel (in_valid, in_stall, in_item): one item per sampled PS/2 bit
//   with the sampled data level, or a home request that reloads the home
//   position and clears the frame and packet counters.
//   out channel (out_valid, out_stall, out_item): one result per completed
//   byte with the byte, the packet-done flag, buttons and cursor position.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): register writes,
//   always ready; unknown indexes are ignored. Write only while idle.
// Throughput: one input item per cycle while in_stall is low. The result of the eleventh
//   edge of a frame is written into the command queue and then loaded into the result
//   register.
// Stalls: edges that finish no byte are always taken. A byte-completing edge
//   or a home request waits only while the command queue is full, which, at the
//   default depth, happens only after the result register has been held by out_stall.
// Reset: counters cleared, buttons released, cursor at the reset home
//   position, registers at their reset values, queue and result empty.
`default_nettype none

module ps2_mouse_receiver_cursor #(
  parameter int QUEUE_DEPTH = pmr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire pmr_pkg::in_item_t                 in_item,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output pmr_pkg::out_item_t                     out_item,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pmr_pkg::IDX_BITS-1:0]      cfg_index,
  input  wire logic [pmr_pkg::DATA_BITS-1:0]     cfg_data
);
  import pmr_pkg::*;

  cfg_t cfg;
  logic q_push;
  cmd_t q_cmd;
  logic q_full;
  logic q_pop;
  logic head_valid;
  cmd_t head_cmd;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capture_enable <= 1'b0;
      cfg.x_max          <= X_MAX_RST;
      cfg.y_max          <= Y_MAX_RST;
      cfg.x_home         <= X_HOME_RST;
      cfg.y_home         <= Y_HOME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CAPTURE: cfg.capture_enable <= cfg_data[0];
        REG_X_MAX:   cfg.x_max          <= cfg_data[POS_BITS-1:0];
        REG_Y_MAX:   cfg.y_max          <= cfg_data[POS_BITS-1:0];
        REG_X_HOME:  cfg.x_home         <= cfg_data[POS_BITS-1:0];
        REG_Y_HOME:  cfg.y_home         <= cfg_data[POS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  pmr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  pmr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  pmr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

>>> rtl/pmr_checker.sv
// Port-level checks for ps2_mouse_receiver_cursor and the bind that
// attaches them. Uses pmr_pkg.
`default_nettype none

module pmr_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_stall,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire pmr_pkg::out_item_t            out_item,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready
);
  import pmr_pkg::*;

  // A held result keeps its contents until transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // The command queue is empty after reset, so no item is held back.
  a_rst_stall: assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_stall)
    else $error("input stalled right after reset");

  // Register writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind ps2_mouse_receiver_cursor pmr_checker u_pmr_checker (.*);

`default_nettype wire

>>> bench/tb_ps2_mouse_receiver_cursor.sv
// Self-checking bench for ps2_mouse_receiver_cursor: directed frame script, then random
// PS/2 item streams checked against an in-bench cursor tracker. Depends on rtl/pmr_pkg.sv
// and the top-level RTL with its submodules.
module tb_ps2_mouse_receiver_cursor;
  timeunit 1ns;
  timeprecision 1ps;

  import pmr_pkg::*;

  localparam int FRAME_LEN      = 11;
  localparam int IDLE_PCT       = 34;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 6;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int TAIL_CYCLES    = 20;
  localparam int PHASE_ITEMS    = 230;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int SCRIPT_LEN     = 30;

  // Register index that decodes to nothing.
  localparam logic [IDX_BITS-1:0] REG_UNKNOWN = 3'd7;

  typedef enum logic [1:0] {
    ROW_FRAME,
    ROW_HOME,
    ROW_PARTIAL,
    ROW_WRITE
  } script_kind_t;

  typedef struct packed {
    script_kind_t          kind;
    logic [IDX_BITS-1:0]   reg_idx;
    logic [DATA_BITS-1:0]  value;
    logic                  typed;
    out_item_t             report;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IDX_BITS-1:0]  cfg_index = '0;
  logic [DATA_BITS-1:0] cfg_data = '0;

  ps2_mouse_receiver_cursor dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracker copy of the configuration and the receiver state.
  logic                cfg_capture;
  logic [POS_BITS-1:0] cfg_x_max, cfg_y_max, cfg_x_home, cfg_y_home;
  logic [3:0]          edges_seen;
  logic [7:0]          shift_reg;
  logic [1:0]          pkt_slot;
  logic [7:0]          pkt_bytes [2];
  logic [1:0]          btn_state;
  logic [POS_BITS-1:0] cur_x, cur_y;

  out_item_t   pending_reports [$];
  out_item_t   want_report;
  int          mismatch_count = 0;
  bit          sender_may_idle = 1'b1;
  bit          receiver_may_idle = 1'b1;
  bit          pressure_go = 1'b0;
  bit          pressure_done = 1'b0;
  script_row_t script [SCRIPT_LEN];

  // One axis step: a negative move must not go below zero, a positive one
  // must not pass the limit; otherwise the position stays put.
  function automatic logic [POS_BITS-1:0] nudge_axis(input logic [POS_BITS-1:0] pos,
                                                     input logic neg, input logic [7:0] delta,
                                                     input logic [POS_BITS-1:0] lim);
    logic [8:0]        mag;
    logic [POS_BITS:0] sum;
    mag = 9'd256 - {1'b0, delta};
    sum = {1'b0, pos} + {3'b000, delta};
    if (neg) begin
      if ({1'b0, pos} >= {2'b00, mag}) return pos - {1'b0, mag};
    end else if (sum <= {1'b0, lim}) begin
      return sum[POS_BITS-1:0];
    end
    return pos;
  endfunction

  // Advance the tracker by one transferred input item; returns 1 when a byte completes.
  function automatic bit track_mouse_edge(input in_item_t it, output out_item_t rep);
    logic [7:0] b;
    logic       done;
    rep = '0;
    if (it.req_type == REQ_HOME) begin
      cur_x = cfg_x_home;
      cur_y = cfg_y_home;
      edges_seen = '0;
      shift_reg = '0;
      pkt_slot = '0;
      return 1'b0;
    end
    edges_seen = edges_seen + 4'd1;
    if (edges_seen >= 4'd2 && edges_seen <= 4'd9) shift_reg = {it.data_level, shift_reg[7:1]};
    if (edges_seen < FRAME_LEN) return 1'b0;
    b = shift_reg;
    edges_seen = '0;
    shift_reg = '0;
    done = 1'b0;
    if (cfg_capture) begin
      if (pkt_slot < 2'd2) begin
        pkt_bytes[pkt_slot[0]] = b;
        pkt_slot = pkt_slot + 2'd1;
      end else begin
        btn_state = pkt_bytes[0][1:0];
        cur_x = nudge_axis(cur_x, pkt_bytes[0][4], pkt_bytes[1], cfg_x_max);
        cur_y = nudge_axis(cur_y, pkt_bytes[0][5], b, cfg_y_max);
        pkt_slot = '0;
        done = 1'b1;
      end
    end
    rep.rx_byte      = b;
    rep.packet_done  = done;
    rep.left_button  = btn_state[0];
    rep.right_button = btn_state[1];
    rep.cursor_x     = cur_x;
    rep.cursor_y     = cur_y;
    return 1'b1;
  endfunction

  function automatic script_row_t script_row(input script_kind_t kind,
                                             input logic [IDX_BITS-1:0] idx,
                                             input logic [DATA_BITS-1:0] value,
                                             input logic typed, input out_item_t report);
    script_row_t r;
    r.kind = kind;
    r.reg_idx = idx;
    r.value = value;
    r.typed = typed;
    r.report = report;
    return r;
  endfunction

  // A result that leaves the cursor at the reset home position.
  function automatic out_item_t home_report(input logic [7:0] b, input logic done,
                                            input logic [1:0] btn);
    return {b, done, btn[0], btn[1], X_HOME_RST, Y_HOME_RST};
  endfunction

  // Offer one item, with random idle cycles first, and wait for its transfer.
  task automatic offer_item(input in_item_t it, input bit use_typed, input out_item_t typed);
    out_item_t rep;
    while (sender_may_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (track_mouse_edge(it, rep)) pending_reports.push_back(use_typed ? typed : rep);
  endtask

  // Full frame: start, data LSB first, odd parity, stop. Noisy frames scramble
  // the framing bits, which the receiver ignores.
  task automatic send_frame(input logic [7:0] value, input bit noisy, input bit use_typed,
                            input out_item_t typed);
    logic [10:0] levels;
    in_item_t    it;
    levels = {1'b1, ~^value, value, 1'b0};
    if (noisy) begin
      levels[0]  = 1'($urandom_range(1));
      levels[9]  = 1'($urandom_range(1));
      levels[10] = 1'($urandom_range(1));
    end
    for (int k = 0; k < FRAME_LEN; k++) begin
      it.req_type   = REQ_EDGE;
      it.data_level = levels[k];
      offer_item(it, use_typed && (k == FRAME_LEN - 1), typed);
    end
  endtask

  task automatic send_home();
    in_item_t it;
    it.req_type   = REQ_HOME;
    it.data_level = 1'($urandom_range(1));
    offer_item(it, 1'b0, '0);
  endtask

  task automatic send_loose_edges(input int count);
    in_item_t it;
    for (int k = 0; k < count; k++) begin
      it.req_type   = REQ_EDGE;
      it.data_level = 1'($urandom_range(1));
      offer_item(it, 1'b0, '0);
    end
  endtask

  // Register write, issued only once every expected result has come out and
  // any home command still in flight has had time to settle.
  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [DATA_BITS-1:0] data);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CAPTURE: cfg_capture = data[0];
      REG_X_MAX:   cfg_x_max   = data;
      REG_Y_MAX:   cfg_y_max   = data;
      REG_X_HOME:  cfg_x_home  = data;
      REG_Y_HOME:  cfg_y_home  = data;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic cap, input logic [9:0] xmax, input logic [9:0] ymax,
                            input logic [9:0] xhome, input logic [9:0] yhome);
    write_reg(REG_CAPTURE, {9'd0, cap});
    write_reg(REG_X_MAX, xmax);
    write_reg(REG_Y_MAX, ymax);
    write_reg(REG_X_HOME, xhome);
    write_reg(REG_Y_HOME, yhome);
    send_home();
  endtask

  // Random traffic: mostly clean frames with random bytes, plus home requests
  // and frames cut short, with or without a home to resync.
  task automatic run_phase(input int n_items);
    int         sent;
    int         pick;
    int         cut;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        if ($urandom_range(99) < 15) begin
          case ($urandom_range(4))
            0: b = 8'h00;
            1: b = 8'hFF;
            2: b = 8'h80;
            3: b = 8'h7F;
            default: b = 8'h01;
          endcase
        end else begin
          b = 8'($urandom_range(255));
        end
        send_frame(b, $urandom_range(99) < 20, 1'b0, '0);
        sent += FRAME_LEN;
      end else if (pick < 88) begin
        send_home();
        sent += 1;
      end else begin
        cut = $urandom_range(1, FRAME_LEN - 1);
        send_loose_edges(cut);
        sent += cut;
        if ($urandom_range(1)) begin
          send_home();
          sent += 1;
        end
      end
    end
  endtask

  // Receiver side: random stalls, one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (pressure_go && !pressure_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        out_stall <= receiver_may_idle && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Result checker: every transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: rx_byte %0h", out_item.rx_byte);
        mismatch_count++;
      end else begin
        want_report = pending_reports.pop_front();
        if (out_item.rx_byte !== want_report.rx_byte) begin
          $error("rx_byte expected %0h actual %0h", want_report.rx_byte, out_item.rx_byte);
          mismatch_count++;
        end
        if (out_item.packet_done !== want_report.packet_done) begin
          $error("packet_done expected %0b actual %0b",
                 want_report.packet_done, out_item.packet_done);
          mismatch_count++;
        end
        if (out_item.left_button !== want_report.left_button) begin
          $error("left_button expected %0b actual %0b",
                 want_report.left_button, out_item.left_button);
          mismatch_count++;
        end
        if (out_item.right_button !== want_report.right_button) begin
          $error("right_button expected %0b actual %0b",
                 want_report.right_button, out_item.right_button);
          mismatch_count++;
        end
        if (out_item.cursor_x !== want_report.cursor_x) begin
          $error("cursor_x expected %0d actual %0d", want_report.cursor_x, out_item.cursor_x);
          mismatch_count++;
        end
        if (out_item.cursor_y !== want_report.cursor_y) begin
          $error("cursor_y expected %0d actual %0d", want_report.cursor_y, out_item.cursor_y);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int waited;
    // Tracker reset state matches the block after reset.
    cfg_capture = 1'b0;
    cfg_x_max   = X_MAX_RST;
    cfg_y_max   = Y_MAX_RST;
    cfg_x_home  = X_HOME_RST;
    cfg_y_home  = Y_HOME_RST;
    edges_seen  = '0;
    shift_reg   = '0;
    pkt_slot    = '0;
    pkt_bytes[0] = '0;
    pkt_bytes[1] = '0;
    btn_state   = '0;
    cur_x       = X_HOME_RST;
    cur_y       = Y_HOME_RST;

    // Directed script. Capture starts disabled, so the first bytes leave the
    // cursor at home; then packets probe the move limits.
    script = '{
      script_row(ROW_FRAME, REG_CAPTURE, 10'h000, 1'b1, home_report(8'h00, 1'b0, 2'b00)),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h0FF, 1'b1, home_report(8'hFF, 1'b0, 2'b00)),
      script_row(ROW_PARTIAL, REG_CAPTURE, 10'd5, 1'b0, '0),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h05A, 1'b1, home_report(8'h5A, 1'b0, 2'b00)),
      // Capture on; the bits above bit 0 are dropped.
      script_row(ROW_WRITE, REG_CAPTURE, 10'h3FF, 1'b0, '0),
      // Negative moves larger than the position (including the zero byte
      // that means 256) leave the cursor where it is.
      script_row(ROW_FRAME, REG_CAPTURE, 10'h033, 1'b1, home_report(8'h33, 1'b0, 2'b00)),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h000, 1'b1, home_report(8'h00, 1'b0, 2'b00)),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h001, 1'b1, home_report(8'h01, 1'b1, 2'b11)),
      // Move exactly to zero; positive move past the limit is refused.
      script_row(ROW_FRAME, REG_CAPTURE, 10'h010, 1'b0, '0),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h010, 1'b0, '0),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h0FF, 1'b0, '0),
      // Largest positive step, and a move landing exactly on the limit.
      script_row(ROW_FRAME, REG_CAPTURE, 10'h000, 1'b0, '0),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h0FF, 1'b0, '0),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h087, 1'b0, '0),
      script_row(ROW_HOME, REG_CAPTURE, 10'h000, 1'b0, '0),
      // Cursor above its maximum: up is refused, down is allowed.
      script_row(ROW_WRITE, REG_X_MAX, 10'd100, 1'b0, '0),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h000, 1'b0, '0),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h001, 1'b0, '0),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h000, 1'b0, '0),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h012, 1'b0, '0),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h080, 1'b0, '0),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h000, 1'b0, '0),
      // A home request in the middle of a packet restarts the packet.
      script_row(ROW_FRAME, REG_CAPTURE, 10'h001, 1'b0, '0),
      script_row(ROW_HOME, REG_CAPTURE, 10'h000, 1'b0, '0),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h010, 1'b0, '0),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h0FF, 1'b0, '0),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h000, 1'b0, '0),
      // Unknown index is ignored; capture off again via bit 0 only.
      script_row(ROW_WRITE, REG_UNKNOWN, 10'h3FF, 1'b0, '0),
      script_row(ROW_WRITE, REG_CAPTURE, 10'h002, 1'b0, '0),
      script_row(ROW_FRAME, REG_CAPTURE, 10'h0A5, 1'b0, '0)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < SCRIPT_LEN; r++) begin
      case (script[r].kind)
        ROW_FRAME:   send_frame(script[r].value[7:0], 1'b0, script[r].typed, script[r].report);
        ROW_HOME:    send_home();
        ROW_PARTIAL: begin
          send_loose_edges(int'(script[r].value));
          send_home();
        end
        default:     write_reg(script[r].reg_idx, script[r].value);
      endcase
    end

    // Reset-value limits; the receiver holds off once so the input stalls.
    set_limits(1'b1, 10'd479, 10'd271, 10'd240, 10'd136);
    pressure_go = 1'b1;
    run_phase(PHASE_ITEMS);

    // Widest limits, home at the corner, no idling on either side.
    set_limits(1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
    sender_may_idle   = 1'b0;
    receiver_may_idle = 1'b0;
    run_phase(PHASE_ITEMS);
    sender_may_idle   = 1'b1;
    receiver_may_idle = 1'b1;

    // Zero limits with home at the origin.
    set_limits(1'b1, 10'd0, 10'd0, 10'd0, 10'd0);
    run_phase(PHASE_ITEMS);

    // Home above both limits: from home the cursor can only move down.
    set_limits(1'b1, 10'd100, 10'd50, 10'd1023, 10'd1023);
    run_phase(PHASE_ITEMS);

    // Capture off with random limits.
    set_limits(1'b0, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
               10'($urandom_range(1023)), 10'($urandom_range(1023)));
    run_phase(PHASE_ITEMS);

    // Capture on with random limits.
    set_limits(1'b1, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
               10'($urandom_range(1023)), 10'($urandom_range(1023)));
    run_phase(PHASE_ITEMS);

    // Drain the outstanding results, then watch a little longer.
    in_valid <= 1'b0;
    waited = 0;
    while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d expected results never arrived", pending_reports.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
